// File: rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types and constants for the infix to postfix converter: symbol
// classes, the queued item between front and back, and result status codes.
// ----------------------------------------------------------------------------
package i2p_pkg;

    // Characters with a meaning of their own
    localparam logic [7:0] LPAREN_CHAR = 8'h28;  // '('
    localparam logic [7:0] RPAREN_CHAR = 8'h29;  // ')'
    localparam logic [7:0] STAR_CHAR   = 8'h2A;  // '*'
    localparam logic [7:0] PLUS_CHAR   = 8'h2B;  // '+'
    localparam logic [7:0] MINUS_CHAR  = 8'h2D;  // '-'
    localparam logic [7:0] SLASH_CHAR  = 8'h2F;  // '/'

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Class of an incoming character
    typedef enum logic [2:0] {
        KIND_OPERAND,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_OP_LOW,
        KIND_OP_HIGH
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNMATCHED = 2'd2
    } t_status;

    // Classified item handed from front to back
    typedef struct packed {
        logic [7:0] symbol;
        t_kind      kind;
        logic       eoe;
    } t_item;

    // Queue head as seen by the back part
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // One result
    typedef struct packed {
        logic [7:0] symbol;
        logic       sym_valid;
        logic       last;
        t_status    status;
    } t_result;

endpackage

// File: rtl/i2p_front.sv
// ----------------------------------------------------------------------------
// i2p_front
// Accepts input characters, classifies them and holds them in a short queue
// so that the stack engine can stall without stalling the input stream.
// ----------------------------------------------------------------------------
module i2p_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_symbol,
    input  logic            i_eoe,
    input  logic            i_pop,
    output i2p_pkg::t_head  o_head
);
    import i2p_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    t_kind          w_kind;
    logic           w_push;

    // Classify the incoming character
    always_comb begin
        unique case (i_symbol) inside
            LPAREN_CHAR:            w_kind = KIND_LPAREN;
            RPAREN_CHAR:            w_kind = KIND_RPAREN;
            PLUS_CHAR, MINUS_CHAR:  w_kind = KIND_OP_LOW;
            STAR_CHAR, SLASH_CHAR:  w_kind = KIND_OP_HIGH;
            default:                w_kind = KIND_OPERAND;
        endcase
    end

    assign o_ready = (r_count != CW'(QUEUE_DEPTH));
    assign w_push  = i_valid && o_ready;

    // Store the classified item
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= '{symbol: i_symbol, kind: w_kind, eoe: i_eoe};
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    // Queue never overfills and is never popped when empty
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(QUEUE_DEPTH)) && !i_pop |=> !o_ready)
        else $error("queue accepts while full");

endmodule

// File: rtl/i2p_back.sv
// ----------------------------------------------------------------------------
// i2p_back
// Operator stack engine: takes classified items from the queue head, moves
// operators on a shift-register stack and emits one result per cycle into an
// output register, unless that register is held by a stalled receiver.
// ----------------------------------------------------------------------------
module i2p_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2p_pkg::t_head    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output i2p_pkg::t_result  o_result
);
    import i2p_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        PH_MAIN,
        PH_FLUSH
    } t_phase;

    logic [7:0]     r_stack [STACK_DEPTH];
    logic [CW-1:0]  r_count;
    t_phase         r_phase;
    logic           r_out_valid;
    t_result        r_out;

    t_phase         n_phase;
    t_result        w_res;
    logic           w_emit;
    logic           w_push;
    logic           w_pop;
    logic           w_finish;
    logic           w_advance;
    logic           w_out_free;
    logic           w_empty;
    logic           w_full;
    logic           w_more;
    logic           w_high;
    logic           w_pops0;
    logic           w_pops1;
    logic [7:0]     w_t0;
    logic [7:0]     w_t1;
    t_item          w_it;

    assign w_it       = i_head.item;
    assign w_t0       = r_stack[0];
    assign w_t1       = r_stack[1];
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_more     = (r_count > CW'(1));
    assign w_high     = (w_it.kind == KIND_OP_HIGH);
    assign w_out_free = !r_out_valid || i_ready;

    // Does the stacked operator give way to the incoming one
    function automatic logic gives_way(input logic high, input logic [7:0] t);
        logic r;
        if (high) begin
            r = (t == STAR_CHAR) || (t == SLASH_CHAR);
        end else begin
            r = (t != LPAREN_CHAR);
        end
        return r;
    endfunction

    assign w_pops0 = !w_empty && gives_way(w_high, w_t0);
    assign w_pops1 = w_more && gives_way(w_high, w_t1);

    // Decide this cycle's step for the item at the queue head
    always_comb begin
        n_phase  = r_phase;
        w_emit   = 1'b0;
        w_push   = 1'b0;
        w_pop    = 1'b0;
        w_finish = 1'b0;
        w_res    = '{symbol: 8'h00, sym_valid: 1'b0, last: 1'b0, status: ST_OK};
        if (r_phase == PH_FLUSH) begin
            w_emit        = 1'b1;
            w_pop         = 1'b1;
            w_res.symbol  = w_t0;
            w_res.sym_valid = 1'b1;
            w_res.last    = (r_count == CW'(1));
            if (r_count == CW'(1)) begin
                w_finish = 1'b1;
                n_phase  = PH_MAIN;
            end
        end else begin
            unique case (w_it.kind) inside
                KIND_LPAREN: begin
                    if (w_full) begin
                        w_emit       = 1'b1;
                        w_res.status = ST_OVERFLOW;
                        w_res.last   = !w_it.eoe;
                    end else begin
                        w_push = 1'b1;
                    end
                    if (w_it.eoe) begin
                        n_phase = PH_FLUSH;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                KIND_RPAREN: begin
                    if (w_empty) begin
                        w_emit       = 1'b1;
                        w_res.status = ST_UNMATCHED;
                        w_res.last   = 1'b1;
                        w_finish     = 1'b1;
                    end else if (w_t0 == LPAREN_CHAR) begin
                        w_pop = 1'b1;
                        if (w_it.eoe && w_more) begin
                            n_phase = PH_FLUSH;
                        end else begin
                            w_finish = 1'b1;
                        end
                    end else begin
                        w_emit          = 1'b1;
                        w_pop           = 1'b1;
                        w_res.symbol    = w_t0;
                        w_res.sym_valid = 1'b1;
                        // Last when the opening bracket is next and no flush follows it
                        w_res.last      = (w_more && (w_t1 == LPAREN_CHAR))
                                          && !(w_it.eoe && (r_count > CW'(2)));
                    end
                end
                KIND_OP_LOW, KIND_OP_HIGH: begin
                    if (w_pops0) begin
                        w_emit          = 1'b1;
                        w_pop           = 1'b1;
                        w_res.symbol    = w_t0;
                        w_res.sym_valid = 1'b1;
                        w_res.last      = !(w_pops1 || w_it.eoe);
                    end else begin
                        if (w_full) begin
                            w_emit       = 1'b1;
                            w_res.status = ST_OVERFLOW;
                            w_res.last   = !w_it.eoe;
                        end else begin
                            w_push = 1'b1;
                        end
                        if (w_it.eoe) begin
                            n_phase = PH_FLUSH;
                        end else begin
                            w_finish = 1'b1;
                        end
                    end
                end
                default: begin
                    // Operand: pass it straight through
                    w_emit          = 1'b1;
                    w_res.symbol    = w_it.symbol;
                    w_res.sym_valid = 1'b1;
                    w_res.last      = !(w_it.eoe && !w_empty);
                    if (w_it.eoe && !w_empty) begin
                        n_phase = PH_FLUSH;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
            endcase
        end
    end

    // Step only when there is an item and room for any result it makes
    assign w_advance = i_head.valid && (!w_emit || w_out_free);
    assign o_pop     = w_advance && w_finish;

    // Shift the stack on push and pop; the top lives in entry zero
    always_ff @(posedge i_clk) begin
        if (w_advance && w_push) begin
            r_stack[0] <= w_it.symbol;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (w_advance && w_pop) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    // Hold phase, stack count and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAIN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_phase <= n_phase;
                if (w_push) begin
                    r_count <= r_count + CW'(1);
                end else if (w_pop) begin
                    r_count <= r_count - CW'(1);
                end
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Stack count stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    // Flushing only runs on a non-empty stack with an item present
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FLUSH) |-> (r_count != '0) && i_head.valid)
        else $error("flush phase with empty stack or no item");

    // Status-only results carry no character and characters carry ok status
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.sym_valid == (r_out.status == ST_OK))
                        && (r_out.sym_valid || r_out.symbol == 8'h00))
        else $error("malformed result");

    // A finished item leaves the phase at main
    a_finish_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_phase == PH_MAIN)
        else $error("item retired while still flushing");

endmodule

// File: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters and
// status results out, using an operator stack of STACK_DEPTH entries.
// ----------------------------------------------------------------------------
// The first result of a character passes the queue, then the stack engine,
//   and leaves from the engine's output register.
// The stack engine steps once per result, and once per character that makes
//   none; popping a '(' or pushing is a step of its own.
// A four-entry queue lets input keep flowing while the engine pops runs.
// Reset (synchronous, active low) empties the queue and the stack.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input characters
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] symbol
    input  logic        i_s_tlast,   // end of expression
    // Postfix results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_symbol
    output logic        o_m_tlast,   // last result of this character
    output logic [2:0]  o_m_tuser    // [0] symbol_valid, [2:1] status
);
    import i2p_pkg::*;

    t_head    w_head;
    logic     w_pop;
    t_result  w_result;

    // Accept, classify and queue
    i2p_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_symbol (i_s_tdata),
        .i_eoe    (i_s_tlast),
        .i_pop    (w_pop),
        .o_head   (w_head)
    );

    // Run the operator stack
    i2p_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = w_result.symbol;
    assign o_m_tlast = w_result.last;
    assign o_m_tuser = {w_result.status, w_result.sym_valid};

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the infix to postfix converter. Directed character
// strings cover every operator, matched and unmatched brackets and flushing.
// Random expressions, deep nests up to overflow and noise bytes follow under
// three idling regimes. A scoreboard object keeps its own operator stack,
// predicts every postfix result and compares each output transaction with it.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import i2p_pkg::*;

    localparam int STACK_DEPTH    = 16;
    localparam int DIRECTED_ITEMS = 22;
    localparam int PHASE_ITEMS    = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // Priority ranks of stacked characters
    localparam int RANK_NONE  = -1;
    localparam int RANK_PAREN = 0;
    localparam int RANK_ADD   = 1;
    localparam int RANK_MUL   = 2;

    // ------------------------------------------------------------------------
    // Postfix scoreboard: shunting-yard predictor and result comparison
    // ------------------------------------------------------------------------
    class postfix_scoreboard;
        logic [7:0]  op_stack [STACK_DEPTH];
        int unsigned depth_used;
        t_result     run_q[$];
        t_result     postfix_q[$];
        int unsigned chars_seen;
        int unsigned results_seen;
        int unsigned overflows;
        int unsigned unmatched;
        int unsigned failures;

        function int rank(logic [7:0] c);
            case (c)
                LPAREN_CHAR:             return RANK_PAREN;
                PLUS_CHAR, MINUS_CHAR:   return RANK_ADD;
                STAR_CHAR, SLASH_CHAR:   return RANK_MUL;
                default:                 return RANK_NONE;
            endcase
        endfunction

        function void emit(logic [7:0] sym, logic valid, t_status st);
            t_result r;
            r.symbol    = sym;
            r.sym_valid = valid;
            r.last      = 1'b0;
            r.status    = st;
            run_q.push_back(r);
        endfunction

        // Push, or flag overflow and drop the character
        function void push_op(logic [7:0] c);
            if (depth_used >= STACK_DEPTH) begin
                emit(8'h00, 1'b0, ST_OVERFLOW);
                overflows++;
            end else begin
                op_stack[depth_used] = c;
                depth_used++;
            end
        endfunction

        function void pop_emit();
            depth_used--;
            emit(op_stack[depth_used], 1'b1, ST_OK);
        endfunction

        // Work out the results of one accepted character
        function void note_char(logic [7:0] sym, logic eoe);
            logic closed;
            run_q.delete();
            chars_seen++;
            if (sym == LPAREN_CHAR) begin
                push_op(sym);
            end else if (sym == RPAREN_CHAR) begin
                closed = 1'b0;
                while (!closed && depth_used > 0) begin
                    if (op_stack[depth_used - 1] == LPAREN_CHAR) begin
                        depth_used--;
                        closed = 1'b1;
                    end else begin
                        pop_emit();
                    end
                end
                if (!closed) begin
                    emit(8'h00, 1'b0, ST_UNMATCHED);
                    unmatched++;
                end
            end else if (rank(sym) > RANK_PAREN) begin
                while (depth_used > 0 && rank(sym) <= rank(op_stack[depth_used - 1]))
                    pop_emit();
                push_op(sym);
            end else begin
                emit(sym, 1'b1, ST_OK);
            end
            // Flush everything left, brackets included
            if (eoe)
                while (depth_used > 0)
                    pop_emit();
            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i])
                postfix_q.push_back(run_q[i]);
        endfunction

        // Compare one output transaction with the oldest expectation
        function void check_result(logic [7:0] sym, logic [2:0] user, logic last);
            t_result want;
            results_seen++;
            if (postfix_q.size() == 0) begin
                $display("%0t: unexpected result sym=%02h valid=%0d last=%0d status=%0d",
                         $realtime, sym, user[0], last, user[2:1]);
                failures++;
                return;
            end
            want = postfix_q.pop_front();
            if (sym !== want.symbol || user[0] !== want.sym_valid ||
                last !== want.last || user[2:1] !== want.status) begin
                $display("%0t: mismatch expected sym=%02h valid=%0d last=%0d status=%0d",
                         $realtime, want.symbol, want.sym_valid, want.last, want.status);
                $display("%0t:          actual   sym=%02h valid=%0d last=%0d status=%0d",
                         $realtime, sym, user[0], last, user[2:1]);
                failures++;
            end
        endfunction

        function int pending();
            return postfix_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] symbol
    logic       i_s_tlast  = 1'b0;    // end of expression
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;            // [7:0] out_symbol
    logic       o_m_tlast;            // last result of this character
    logic [2:0] o_m_tuser;            // [0] symbol_valid, [2:1] status

    postfix_scoreboard sb = new;

    int unsigned chars_sent    = 0;
    int          src_idle_pct  = 0;
    int          snk_idle_pct  = 0;
    int          hold_request  = 0;

    wire s_fire = i_s_tvalid && o_s_tready;
    wire m_fire = o_m_tvalid && i_m_tready;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Check every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_fire)
            sb.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // Receiver: random stalls, with a long hold-off on request
    initial begin : result_sink
        int held;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                i_m_tready <= 1'b0;
                held = 0;
                while (held < hold_request) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_request = 0;
            end
            i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || s_fire || m_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("infix_to_postfix_converter regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Character generation and driving
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0:       return PLUS_CHAR;
            1:       return MINUS_CHAR;
            2:       return STAR_CHAR;
            default: return SLASH_CHAR;
        endcase
    endfunction

    function automatic bit is_special(logic [7:0] c);
        return c == LPAREN_CHAR || c == RPAREN_CHAR || c == PLUS_CHAR ||
               c == MINUS_CHAR || c == STAR_CHAR || c == SLASH_CHAR;
    endfunction

    // Mostly letters, sometimes any non-special byte
    function automatic logic [7:0] rand_operand();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 75)
            return 8'h61 + 8'($urandom_range(0, 25));
        do
            c = 8'($urandom_range(0, 255));
        while (is_special(c));
        return c;
    endfunction

    // Offer one character and hold it until taken; called and left at a falling edge
    task automatic send_char(logic [7:0] sym, logic eoe);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sym;
        i_s_tlast  <= eoe;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        sb.note_char(sym, eoe);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, logic eoe_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eoe_last && i == s.len() - 1);
    endtask

    task automatic send_chars(logic [7:0] chars[$], logic eoe_last);
        foreach (chars[i])
            send_char(chars[i], eoe_last && i == chars.size() - 1);
    endtask

    // Well-formed expression with random nesting, end flag on the last character
    task automatic send_expr();
        logic [7:0] chars[$];
        int         depth;
        int         n_operands;
        depth      = 0;
        n_operands = $urandom_range(1, 6);
        for (int k = 0; k < n_operands; k++) begin
            while (depth < 5 && $urandom_range(0, 99) < 25) begin
                chars.push_back(LPAREN_CHAR);
                depth++;
            end
            chars.push_back(rand_operand());
            while (depth > 0 && $urandom_range(0, 99) < 30) begin
                chars.push_back(RPAREN_CHAR);
                depth--;
            end
            if (k < n_operands - 1)
                chars.push_back(rand_op());
        end
        while (depth > 0) begin
            chars.push_back(RPAREN_CHAR);
            depth--;
        end
        send_chars(chars, 1'b1);
    endtask

    // Deep stacking of brackets and operators to reach overflow
    task automatic send_nest(int count, int paren_pct);
        logic [7:0] chars[$];
        repeat (count)
            chars.push_back(($urandom_range(0, 99) < paren_pct) ? LPAREN_CHAR : rand_op());
        send_chars(chars, 1'($urandom_range(0, 1)));
    endtask

    // Random bytes, special characters favoured, random end flags
    task automatic send_noise();
        logic [7:0] c;
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0:       c = LPAREN_CHAR;
                1:       c = RPAREN_CHAR;
                2, 3:    c = rand_op();
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_char(c, 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned phase_end;
        int          pick;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed characters
        src_idle_pct = 24;
        snk_idle_pct = 86;
        send_char(8'h00, 1'b0);              // NUL is an operand
        send_text("(a+b)*c/d-e", 1'b1);      // all operators, priorities, brackets
        send_char(RPAREN_CHAR, 1'b1);        // closing bracket on an empty stack
        send_text("p-q)", 1'b1);             // pops then finds no opening bracket
        send_text("((-", 1'b1);              // flush with open brackets left
        send_char(8'hFF, 1'b1);
        send_char(8'h20, 1'b0);

        // Random phases: sender-light/receiver-heavy, swapped, then no idling
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 86 : 0;
            snk_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 24 : 0;
            if (phase == 2)
                hold_request = HOLD_CYCLES;
            phase_end = DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS;
            send_nest(STACK_DEPTH + 2, 100);
            while (chars_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    send_expr();
                else if (pick < 75)
                    send_nest($urandom_range(12, 20), 80);
                else
                    send_noise();
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow for stray results
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d characters into %0d results under three stall regimes",
                 sb.chars_seen, sb.results_seen);
        $display("Stack overflows seen: %0d, unmatched closing brackets seen: %0d",
                 sb.overflows, sb.unmatched);
        if (sb.failures == 0) begin
            $display("infix_to_postfix_converter regression: pass");
        end else begin
            $display("infix_to_postfix_converter regression: fail");
        end
        $finish;
    end

endmodule
